// ===== design/ready_to_send_pin_queue_core_assert.svh =====
// Assertion macros for the ready-to-send pin queue.
// Included by the modules that carry checks; empty under synthesis.
`ifndef READY_TO_SEND_PIN_QUEUE_CORE_ASSERT_SVH
`define READY_TO_SEND_PIN_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RTS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/rtspq_pkg.sv =====
// Shared types and constants for the ready-to-send pin queue.
// No dependencies.
package rtspq_pkg;
    localparam int DEF_MAX_DEVICES     = 16;
    localparam int DEF_PINS_PER_DEVICE = 32;
    localparam int DEF_QUEUE_DEPTH     = 64;
    localparam int DEF_MAX_EDGES       = 256;

    localparam logic [2:0] REQ_SET_EDGES   = 3'd0;
    localparam logic [2:0] REQ_SET_OUTPUTS = 3'd1;
    localparam logic [2:0] REQ_READY_MASK  = 3'd2;
    localparam logic [2:0] REQ_SEND_SLOT   = 3'd3;
    localparam logic [2:0] REQ_FLUSH       = 3'd4;

    localparam int IN_W  = 53;
    localparam int IN_WB = 56;
    localparam int OUT_W = 34;
    localparam int OUT_WB = 40;

    typedef struct packed {
        logic start;
        logic clr_step;
        logic mask_rd;
        logic mask_step;
        logic send_rd;
        logic send_tab;
        logic send_wr;
        logic flush_rd;
        logic flush_wr;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic mask_last;
        logic flush_empty;
        logic [2:0] req;
    } t_stat;
endpackage

// ===== design/rtspq_ctrl.sv =====
// Controller state machine of the ready-to-send pin queue.
// Depends on rtspq_pkg and the assertion header.
`include "ready_to_send_pin_queue_core_assert.svh"
module rtspq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_fire,
    input  logic             i_out_busy,
    input  rtspq_pkg::t_stat i_stat,
    output rtspq_pkg::t_cmd  o_cmd,
    output logic             o_idle
);
    import rtspq_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_MASK_RD, S_MASK_WR, S_SEND_RD, S_SEND_TAB,
        S_SEND_WR, S_DONE, S_FLUSH_RD, S_FLUSH_WR
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.start = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.req)
                    REQ_READY_MASK: n_state = S_MASK_RD;
                    REQ_SEND_SLOT:  n_state = i_stat.flush_empty ? S_DONE : S_SEND_RD;
                    REQ_FLUSH:      n_state = S_FLUSH_RD;
                    default: begin
                        if (!i_out_busy) begin
                            o_cmd.finish = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_MASK_RD: begin
                if (i_stat.mask_last) begin
                    if (!i_out_busy) begin
                        o_cmd.finish = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.mask_rd = 1'b1;
                    n_state = S_MASK_WR;
                end
            end
            S_MASK_WR: begin
                o_cmd.mask_step = 1'b1;
                n_state = S_MASK_RD;
            end
            S_SEND_RD: begin
                o_cmd.send_rd = 1'b1;
                n_state = S_SEND_TAB;
            end
            S_SEND_TAB: begin
                o_cmd.send_tab = 1'b1;
                n_state = S_SEND_WR;
            end
            S_SEND_WR: begin
                o_cmd.send_wr = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FLUSH_RD: begin
                if (i_stat.flush_empty) begin
                    if (!i_out_busy) begin
                        o_cmd.finish = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.flush_rd = 1'b1;
                    n_state = S_FLUSH_WR;
                end
            end
            S_FLUSH_WR: begin
                o_cmd.flush_wr = 1'b1;
                n_state = S_FLUSH_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

    assign o_idle = (r_state == S_IDLE);

    `RTS_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, o_cmd.start, r_state == S_IDLE)
    `RTS_ASSERT_NXT(a_flush_back, i_clk, i_rst_n, o_cmd.flush_wr, r_state == S_FLUSH_RD)
    `RTS_ASSERT_IMP(a_finish_free, i_clk, i_rst_n, o_cmd.finish, !i_out_busy)
endmodule

// ===== design/rtspq_dp.sv =====
// Datapath of the ready-to-send pin queue: pin tables, ring and result register.
// Depends on rtspq_pkg and the assertion header.
`include "ready_to_send_pin_queue_core_assert.svh"
module rtspq_dp #(
    parameter int QUEUE_DEPTH     = rtspq_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_EDGES       = rtspq_pkg::DEF_MAX_EDGES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rtspq_pkg::t_cmd  i_cmd,
    input  logic [2:0]       i_req_type,
    input  logic [3:0]       i_device,
    input  logic [4:0]       i_pin,
    input  logic [8:0]       i_count,
    input  logic [31:0]      i_ready_mask,
    output rtspq_pkg::t_stat o_stat,
    output logic [rtspq_pkg::OUT_W-1:0] o_result
);
    import rtspq_pkg::*;

    localparam int MAX_DEVICES     = DEF_MAX_DEVICES;
    localparam int PINS_PER_DEVICE = DEF_PINS_PER_DEVICE;
    localparam int NUM_PINS = MAX_DEVICES * PINS_PER_DEVICE;
    localparam int DW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int PW = (PINS_PER_DEVICE > 1) ? $clog2(PINS_PER_DEVICE) : 1;
    localparam int IW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int OCW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = $clog2(MAX_EDGES + 1);
    localparam int CW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int OPW = $clog2(PINS_PER_DEVICE + 1);

    // pin table: {pending, cursor, edge count}
    localparam int TW = 1 + CW + EW;
    logic [TW-1:0] r_tab [NUM_PINS];
    logic [OPW-1:0] r_opd [MAX_DEVICES];
    logic [IW-1:0] r_ring [QUEUE_DEPTH];

    logic [2:0]  r_req;
    logic [3:0]  r_dev;
    logic [31:0] r_mask;
    logic [5:0]  r_i;
    logic [IW:0] r_clr;
    logic [QW-1:0] r_head, r_tail;
    logic [OCW-1:0] r_occ;
    logic [5:0] r_added;
    logic r_ovf;
    logic [IW-1:0] r_id;
    logic [TW-1:0] r_ent;
    logic [1+4+5+8+1+1-1:0] r_send;

    logic dev_ok;
    logic [OPW-1:0] n_lim;
    logic [IW-1:0] mask_id, tab_idx, rd_idx;
    logic mask_live;
    logic [EW-1:0] ent_tot;
    logic [CW-1:0] ent_cur;
    logic [EW:0] cur_inc;
    logic send_done;

    assign dev_ok = (32'(r_dev) < MAX_DEVICES);
    assign n_lim  = dev_ok ? r_opd[r_dev[DW-1:0]] : '0;
    assign mask_id = IW'(32'(r_dev) * PINS_PER_DEVICE + 32'(r_i));
    assign mask_live = ({26'd0, r_i} < 32'(n_lim)) && r_mask[r_i[4:0]];
    assign tab_idx = r_clr[IW-1:0];
    assign rd_idx = i_cmd.send_tab ? r_id : mask_id;

    assign ent_tot = r_ent[EW-1:0];
    assign ent_cur = r_ent[EW +: CW];
    assign cur_inc = (EW+1)'(ent_cur) + 1'b1;
    assign send_done = (cur_inc >= (EW+1)'(ent_tot));

    assign o_stat.clr_last    = (r_clr == (IW+1)'(NUM_PINS - 1));
    assign o_stat.mask_last   = !dev_ok || (r_i == 6'd32) || ({26'd0, r_i} >= 32'(n_lim));
    assign o_stat.flush_empty = (r_occ == '0);
    assign o_stat.req         = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req <= i_req_type;
            r_dev <= i_device;
            r_mask <= i_ready_mask;
            r_i <= '0;
        end else if (i_cmd.mask_step) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.send_rd || i_cmd.flush_rd) begin
            r_id <= r_ring[r_head];
        end
    end

    // ring and table writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_tab[tab_idx] <= '0;
        end else if (i_cmd.start && i_req_type == REQ_SET_EDGES
                     && 32'(i_device) < MAX_DEVICES && 32'(i_pin) < PINS_PER_DEVICE) begin
            r_tab[IW'(32'(i_device) * PINS_PER_DEVICE + 32'(i_pin))][EW-1:0] <=
                (32'(i_count) > MAX_EDGES) ? EW'(MAX_EDGES) : EW'(i_count);
        end else if (i_cmd.mask_step && mask_live && !r_ent[TW-1]
                     && r_occ != OCW'(QUEUE_DEPTH)) begin
            r_tab[mask_id][TW-1] <= 1'b1;
            r_ring[r_tail] <= mask_id;
        end else if (i_cmd.send_wr) begin
            r_tab[r_id][TW-1] <= !send_done;
            r_tab[r_id][EW +: CW] <= send_done ? '0 : CW'(cur_inc);
        end else if (i_cmd.flush_wr) begin
            r_tab[r_id][TW-1] <= 1'b0;
            r_tab[r_id][EW +: CW] <= '0;
        end
        if (i_cmd.mask_rd || i_cmd.send_tab) begin
            r_ent <= r_tab[rd_idx];
        end
        if (i_cmd.clr_step && r_clr < (IW+1)'(MAX_DEVICES)) begin
            r_opd[r_clr[DW-1:0]] <= '0;
        end else if (i_cmd.start && i_req_type == REQ_SET_OUTPUTS
                     && 32'(i_device) < MAX_DEVICES) begin
            r_opd[i_device[DW-1:0]] <= (32'(i_count) > PINS_PER_DEVICE)
                ? OPW'(PINS_PER_DEVICE) : OPW'(i_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
        end else if (i_cmd.start) begin
            r_added <= '0;
            r_ovf <= 1'b0;
            r_send <= '0;
        end else if (i_cmd.mask_step) begin
            if (mask_live && !r_ent[TW-1]) begin
                if (r_occ == OCW'(QUEUE_DEPTH)) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_tail <= (32'(r_tail) == QUEUE_DEPTH - 1) ? '0 : r_tail + 1'b1;
                    r_occ <= r_occ + 1'b1;
                    r_added <= r_added + 1'b1;
                end
            end
        end else if (i_cmd.send_wr) begin
            if (r_occ != '0) begin
                r_send <= {send_done, ent_tot == '0, 8'(ent_cur),
                           5'(32'(r_id) % PINS_PER_DEVICE), 4'(r_id >> PW), 1'b1};
                if (send_done) begin
                    r_head <= (32'(r_head) == QUEUE_DEPTH - 1) ? '0 : r_head + 1'b1;
                    r_occ <= r_occ - 1'b1;
                end
            end
        end else if (i_cmd.flush_wr) begin
            r_head <= (32'(r_head) == QUEUE_DEPTH - 1) ? '0 : r_head + 1'b1;
            r_occ <= r_occ - 1'b1;
        end
    end

    logic [OUT_W-1:0] res_now;
    assign res_now = {7'(r_occ), r_ovf, r_added, r_send};
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) o_result <= res_now;
    end

    `RTS_ASSERT_IMP(a_occ_range, i_clk, i_rst_n, 1'b1, r_occ <= OCW'(QUEUE_DEPTH))
    `RTS_ASSERT_NXT(a_flush_dec, i_clk, i_rst_n, i_cmd.flush_wr, r_occ == $past(r_occ) - 1'b1)
    `RTS_ASSERT_IMP(a_send_nonempty, i_clk, i_rst_n, i_cmd.send_wr, r_occ != '0)
endmodule

// ===== design/ready_to_send_pin_queue_core.sv =====
// Top level of the ready-to-send pin queue: stream ports, controller and datapath.
// Depends on rtspq_pkg, rtspq_ctrl and rtspq_dp.
// One item at a time. After reset a clearing pass over every pin entry
// empties the pin tables before the first item is taken. A send slot steps
// through read, table read and write states (skipped on an empty queue); a
// ready mask takes a read and a step state per checked pin, a flush a read and
// a write state per queued pin; a result still waiting in the output register
// holds the finish of the next item, which is otherwise taken while it waits.
module ready_to_send_pin_queue_core #(
    parameter int QUEUE_DEPTH     = rtspq_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_EDGES       = rtspq_pkg::DEF_MAX_EDGES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // req_type[2:0], device[6:3], pin[11:7], count[20:12], ready_mask[52:21]
    input  logic [rtspq_pkg::IN_WB-1:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // send_valid[0], send_device[4:1], send_pin[9:5], edge_index[17:10],
    // no_edges[18], pin_done[19], enqueued[25:20], overflow[26], queue_count[33:27]
    output logic [rtspq_pkg::OUT_WB-1:0] m_axis_tdata
);
    import rtspq_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  idle, fire, r_ovalid;
    logic [OUT_W-1:0] result;

    assign s_axis_tready = idle;
    assign fire = s_axis_tvalid && idle;

    rtspq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(fire),
        .i_out_busy(r_ovalid && !m_axis_tready), .i_stat(stat), .o_cmd(cmd), .o_idle(idle)
    );

    rtspq_dp #(
        .QUEUE_DEPTH(QUEUE_DEPTH), .MAX_EDGES(MAX_EDGES)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_req_type(s_axis_tdata[2:0]), .i_device(s_axis_tdata[6:3]),
        .i_pin(s_axis_tdata[11:7]), .i_count(s_axis_tdata[20:12]),
        .i_ready_mask(s_axis_tdata[52:21]), .o_stat(stat), .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (cmd.finish) r_ovalid <= 1'b1;
        else if (m_axis_tready) r_ovalid <= 1'b0;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {{(OUT_WB-OUT_W){1'b0}}, result};
endmodule

// ===== tb/tb_ready_to_send_pin_queue_core.sv =====
// Testbench for the ready-to-send pin queue core: directed table, then random requests.
// Results are checked against an in-bench model of the pin tables and ring.
// Depends on rtspq_pkg and ready_to_send_pin_queue_core.
module tb_ready_to_send_pin_queue_core;
    timeunit 1ns;
    timeprecision 1ps;
    import rtspq_pkg::*;

    localparam int NDEV = DEF_MAX_DEVICES;
    localparam int NPIN = DEF_PINS_PER_DEVICE;
    localparam int QD   = DEF_QUEUE_DEPTH;
    localparam int MAXE = DEF_MAX_EDGES;
    localparam int NIDS = NDEV * NPIN;

    typedef struct packed {
        logic [6:0] queue_count;
        logic       overflow;
        logic [5:0] enqueued;
        logic       pin_done;
        logic       no_edges;
        logic [7:0] edge_index;
        logic [4:0] send_pin;
        logic [3:0] send_device;
        logic       send_valid;
    } t_res;

    typedef struct packed {
        logic [31:0] ready_mask;
        logic [8:0]  count;
        logic [4:0]  pin;
        logic [3:0]  device;
        logic [2:0]  req_type;
    } t_req;

    typedef struct {
        t_req req;
        logic has_res;
        t_res res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [IN_WB-1:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [OUT_WB-1:0] m_axis_tdata;

    ready_to_send_pin_queue_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    logic       pend[NIDS];
    int         cursor[NIDS];
    int         edge_total[NIDS];
    int         outs_per_dev[NDEV];
    int         ring[QD];
    int         head, tail, occ;
    t_res       expected_q[$];
    int         errors = 0;
    bit         stim_done = 0;

    function automatic t_res predict_pin_queue(t_req r);
        t_res o;
        int   id, n;
        o = '0;
        case (r.req_type)
            REQ_SET_EDGES:
                edge_total[r.device * NPIN + r.pin] = (r.count > MAXE) ? MAXE : r.count;
            REQ_SET_OUTPUTS:
                outs_per_dev[r.device] = (r.count > NPIN) ? NPIN : r.count;
            REQ_READY_MASK: begin
                n = outs_per_dev[r.device];
                for (int i = 0; i < n; i++) begin
                    id = r.device * NPIN + i;
                    if (r.ready_mask[i] && !pend[id]) begin
                        if (occ >= QD) begin
                            o.overflow = 1'b1;
                        end else begin
                            pend[id] = 1'b1;
                            ring[tail] = id;
                            tail = (tail + 1) % QD;
                            occ++;
                            o.enqueued++;
                        end
                    end
                end
            end
            REQ_SEND_SLOT: begin
                if (occ > 0) begin
                    id = ring[head];
                    o.send_valid  = 1'b1;
                    o.send_device = 4'(id / NPIN);
                    o.send_pin    = 5'(id % NPIN);
                    o.edge_index  = 8'(cursor[id]);
                    o.no_edges    = (edge_total[id] == 0);
                    cursor[id]++;
                    if (cursor[id] >= edge_total[id]) begin
                        cursor[id] = 0;
                        pend[id] = 1'b0;
                        head = (head + 1) % QD;
                        occ--;
                        o.pin_done = 1'b1;
                    end
                end
            end
            REQ_FLUSH: begin
                while (occ > 0) begin
                    id = ring[head];
                    cursor[id] = 0;
                    pend[id] = 1'b0;
                    head = (head + 1) % QD;
                    occ--;
                end
            end
            default: ;
        endcase
        o.queue_count = 7'(occ);
        return o;
    endfunction

    function automatic t_req mk(logic [2:0] t, int d, int p, int c, logic [31:0] m);
        t_req r;
        r.req_type = t; r.device = 4'(d); r.pin = 5'(p); r.count = 9'(c); r.ready_mask = m;
        return r;
    endfunction

    task automatic send_item(t_req r, logic has_res, t_res res);
        t_res p;
        if ($urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tdata  <= IN_WB'(r);
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        p = predict_pin_queue(r);
        if (has_res && p != res) begin
            $display("%0t table row disagrees: expected %h model %h", $time, res, p);
            errors++;
        end
        expected_q.push_back(p);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic t_res rs(int qc);
        t_res o;
        o = '0; o.queue_count = 7'(qc);
        return o;
    endfunction

    // Receiver stall pattern and result check
    int stall_phase = 0;
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_res'(m_axis_tdata[OUT_W-1:0]);
                if (expected_q.size() == 0) begin
                    $display("%0t unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (got != want) begin
                        $display("%0t mismatch: expected %h actual %h", $time, want, got);
                        errors++;
                    end
                end
            end
            stall_phase <= stall_phase + 1;
            if (stall_phase % 200 < 60) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    t_row rows[$];
    t_res r0;

    initial begin
        t_req r;
        int kind, dev, burst;
        bit drained_mid;
        drained_mid = 0;
        foreach (pend[i]) begin
            pend[i] = 0; cursor[i] = 0; edge_total[i] = 0;
        end
        foreach (outs_per_dev[i]) outs_per_dev[i] = 0;
        foreach (ring[i]) ring[i] = 0;
        head = 0; tail = 0; occ = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        r0 = '0;
        rows.push_back(t_row'{mk(REQ_SEND_SLOT, 0, 0, 0, 0), 1, rs(0)});
        rows.push_back(t_row'{mk(REQ_READY_MASK, 0, 0, 0, '1), 1, rs(0)});
        rows.push_back(t_row'{mk(REQ_SET_OUTPUTS, 15, 0, 511, 0), 1, rs(0)});
        rows.push_back(t_row'{mk(REQ_SET_OUTPUTS, 0, 0, 1, 0), 1, rs(0)});
        rows.push_back(t_row'{mk(REQ_SET_EDGES, 15, 31, 511, 0), 1, rs(0)});
        rows.push_back(t_row'{mk(REQ_SET_EDGES, 0, 0, 2, 0), 1, rs(0)});
        rows.push_back(t_row'{mk(REQ_READY_MASK, 0, 0, 0, 32'h1), 0, r0});
        rows.push_back(t_row'{mk(REQ_READY_MASK, 0, 0, 0, 32'h1), 0, r0});
        rows.push_back(t_row'{mk(REQ_SEND_SLOT, 0, 0, 0, 0), 0, r0});
        rows.push_back(t_row'{mk(REQ_SET_EDGES, 0, 0, 0, 0), 0, r0});
        rows.push_back(t_row'{mk(REQ_SEND_SLOT, 0, 0, 0, 0), 0, r0});
        rows.push_back(t_row'{mk(REQ_READY_MASK, 15, 0, 0, '1), 0, r0});
        rows.push_back(t_row'{mk(REQ_SET_OUTPUTS, 14, 0, 32, 0), 0, r0});
        rows.push_back(t_row'{mk(REQ_READY_MASK, 14, 0, 0, '1), 0, r0});
        rows.push_back(t_row'{mk(REQ_READY_MASK, 0, 0, 0, 32'h1), 0, r0});
        rows.push_back(t_row'{mk(REQ_SEND_SLOT, 0, 0, 0, 0), 0, r0});
        rows.push_back(t_row'{mk(3'd7, 5, 5, 5, 32'h5), 0, r0});
        rows.push_back(t_row'{mk(REQ_FLUSH, 0, 0, 0, 0), 1, rs(0)});
        rows.push_back(t_row'{mk(3'd5, 0, 0, 0, 0), 1, rs(0)});
        foreach (rows[i]) send_item(rows[i].req, rows[i].has_res, rows[i].res);
        wait_drained();

        for (int n = 0; n < 1000; ) begin
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst && n < 1000; b++, n++) begin
                dev = $urandom_range(0, 3);
                if ($urandom_range(0, 9) == 0) dev = $urandom_range(0, NDEV - 1);
                kind = $urandom_range(0, 99);
                if (kind < 10)
                    r = mk(REQ_SET_EDGES, dev, $urandom_range(0, 31),
                           ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                       : $urandom_range(0, 4), 0);
                else if (kind < 16)
                    r = mk(REQ_SET_OUTPUTS, dev, $urandom_range(0, 31),
                           ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511)
                                                       : $urandom_range(0, 32), 0);
                else if (kind < 40)
                    r = mk(REQ_READY_MASK, dev, $urandom_range(0, 31),
                           $urandom_range(0, 511), $urandom());
                else if (kind < 94)
                    r = mk(REQ_SEND_SLOT, dev, $urandom_range(0, 31),
                           $urandom_range(0, 511), $urandom());
                else if (kind < 97)
                    r = mk(REQ_FLUSH, dev, 0, 0, $urandom());
                else
                    r = mk(3'($urandom_range(5, 7)), dev, $urandom_range(0, 31),
                           $urandom_range(0, 511), $urandom());
                send_item(r, 0, r0);
            end
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            if (n >= 500 && !drained_mid) begin
                wait_drained();
                drained_mid = 1;
            end
        end
        wait_drained();
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (errors == 0) begin
            $display("PASS ready_to_send_pin_queue_core");
        end else begin
            $display("FAIL ready_to_send_pin_queue_core");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL ready_to_send_pin_queue_core");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/rtspq_pkg.sv
design/rtspq_ctrl.sv
design/rtspq_dp.sv
design/ready_to_send_pin_queue_core.sv
tb/tb_ready_to_send_pin_queue_core.sv
